@@ design/cadsr_pkg.sv @@
package cadsr_pkg;

  localparam int FB = 24;
  localparam int LVL_W = FB + 1;
  localparam int CURVE_W = 16;
  localparam int CYC_W = 32;
  localparam int MODE_W = 3;
  localparam int FUNC_W = 2;
  localparam int TIDX_W = 10;
  localparam int PHASE_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WGT_W = CURVE_W + 1;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SEARCH_STEPS_DEF = 16;

  localparam longint ONE_L = 64'd1 << FB;
  localparam logic [LVL_W-1:0] ONE = LVL_W'(ONE_L);
  localparam logic [LVL_W-1:0] HI_MARK = LVL_W'((ONE_L * 999 + 999) / 1000);
  localparam logic [LVL_W-1:0] HI_CLAMP = LVL_W'((ONE_L * 999) / 1000);
  localparam logic [LVL_W-1:0] LO_MARK = LVL_W'(ONE_L / 1000);
  localparam logic [LVL_W-1:0] TOL = LVL_W'(ONE_L / 20);
  localparam logic [WGT_W-1:0] CURVE_UNIT = WGT_W'(32768);

  localparam logic [FUNC_W-1:0] FN_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ON = 2'd1;
  localparam logic [FUNC_W-1:0] FN_OFF = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TWRITE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_CURVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_CURVE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd7;

  localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ATT = 4'd1;
  localparam logic [PHASE_W-1:0] PH_DEC = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SUS = 4'd3;
  localparam logic [PHASE_W-1:0] PH_REL = 4'd4;
  localparam logic [PHASE_W-1:0] PH_CATT = 4'd5;
  localparam logic [PHASE_W-1:0] PH_CDEC = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CREL = 4'd7;
  localparam logic [PHASE_W-1:0] PH_WAIT = 4'd8;

endpackage

@@ design/cadsr_in_if.sv @@
interface cadsr_in_if;
  logic valid;
  logic ready;
  logic [cadsr_pkg::FUNC_W-1:0] func;
  logic [cadsr_pkg::TIDX_W-1:0] table_index;
  logic [cadsr_pkg::LVL_W-1:0] table_value;
  modport source(output valid, func, table_index, table_value, input ready);
  modport sink(input valid, func, table_index, table_value, output ready);
endinterface

@@ design/cadsr_out_if.sv @@
interface cadsr_out_if;
  logic valid;
  logic ready;
  logic [cadsr_pkg::LVL_W-1:0] level;
  logic [cadsr_pkg::PHASE_W-1:0] phase;
  modport source(output valid, level, phase, input ready);
  modport sink(input valid, level, phase, output ready);
endinterface

@@ design/cadsr_cfg_if.sv @@
interface cadsr_cfg_if;
  logic valid;
  logic ready;
  logic [cadsr_pkg::CFG_IDX_W-1:0] index;
  logic [cadsr_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/cadsr_ram.sv @@
module cadsr_ram #(
  parameter int WIDTH = cadsr_pkg::LVL_W,
  parameter int DEPTH = cadsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/curved_adsr_envelope.sv @@
// ADSR envelope with table-shaped, curvature-blended segments. Each input
// transfer is one event: note on, note off and curve table writes give no
// result; a tick gives one level/phase result. The curve table sits in a
// registered-read RAM; each curve evaluation reads two neighboring entries
// and runs two multiplies for the interpolation and two for the blend, each
// in its own step. A tick in idle, sustain or sync wait goes from prep to
// output; attack adds a curve evaluation, decay also a scale step and
// release a step-down too, and the first release tick adds a bisection index
// search of up to SEARCH_STEPS+1 curve evaluations. The result waits in an
// output register, so a new event is taken while an earlier result is still
// pending. The table has no reset; read only entries that were written.
module curved_adsr_envelope #(
  parameter int TABLE_DEPTH = cadsr_pkg::TABLE_DEPTH_DEF,
  parameter int SEARCH_STEPS = cadsr_pkg::SEARCH_STEPS_DEF
) (
  input logic clk,
  input logic rst_n,
  cadsr_cfg_if.sink cfg_ch,
  cadsr_in_if.sink in_ch,
  cadsr_out_if.source out_ch
);

  localparam int LW = cadsr_pkg::LVL_W;
  localparam int FB = cadsr_pkg::FB;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = AW + 1;
  localparam int POS_W = LW + XW;
  localparam int PW = 2 * LW;
  localparam int BW = cadsr_pkg::WGT_W + LW;
  localparam int SW = $clog2(SEARCH_STEPS + 1);
  localparam logic [XW-1:0] X_MAX = XW'(TABLE_DEPTH - 1);
  localparam logic [LW-1:0] ONE = cadsr_pkg::ONE;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_RELC  = 14'b00000000000100,
    S_CV0   = 14'b00000000001000,
    S_CV1   = 14'b00000000010000,
    S_CV2   = 14'b00000000100000,
    S_CV3   = 14'b00000001000000,
    S_CV4   = 14'b00000010000000,
    S_CV5   = 14'b00000100000000,
    S_CV6   = 14'b00001000000000,
    S_SRCH  = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  logic [LW-1:0] attack_step_r, decay_step_r, release_step_r, sustain_r;
  logic signed [cadsr_pkg::CURVE_W-1:0] attack_curve_r, fall_curve_r;
  logic [cadsr_pkg::CYC_W-1:0] cycle_len_r;
  logic [cadsr_pkg::MODE_W-1:0] mode_r;

  state_t state_r, state_nxt;
  logic [cadsr_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [LW-1:0] idx_r, idx_nxt, level_r, level_nxt, origin_r, origin_nxt;
  logic [cadsr_pkg::CYC_W-1:0] elapsed_r, elapsed_nxt;
  logic due_r, due_nxt, cyc_r, cyc_nxt, rising_r, rising_nxt, search_r, search_nxt;
  logic [LW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [LW-1:0] cv_idx_r, cv_idx_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [FB-1:0] frac_r, frac_nxt;
  logic [PW-1:0] p1_r, p1_nxt, p2_r, p2_nxt, prod_r, prod_nxt;
  logic [LW-1:0] term_r, term_nxt, cv_r, cv_nxt;
  logic [BW-1:0] bw1_r, bw1_nxt, bw2_r, bw2_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_level_r, out_level_nxt;
  logic [cadsr_pkg::PHASE_W-1:0] out_phase_r, out_phase_nxt;

  logic in_xfer;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata, ram_rdata;

  logic signed [cadsr_pkg::CURVE_W-1:0] crv;
  logic signed [cadsr_pkg::CURVE_W+1:0] crv_x, wl_s, wt_s;
  logic mirror, inv, comp;
  logic [cadsr_pkg::WGT_W-1:0] w_lin, w_tab;
  logic [LW-1:0] sus, tv, on_idx;
  logic [cadsr_pkg::PHASE_W-1:0] on_phase;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;
  assign out_ch.phase = out_phase_r;

  assign sus = (sustain_r > ONE) ? ONE : sustain_r;
  assign on_phase = (mode_r[1:0] != 2'b00) ? cadsr_pkg::PH_CATT : cadsr_pkg::PH_ATT;
  assign on_idx = '0;

  assign crv = rising_r ? attack_curve_r : fall_curve_r;
  assign crv_x = (cadsr_pkg::CURVE_W + 2)'(crv);
  assign mirror = rising_r ? (crv > 0) : (crv >= 0);
  assign inv = !rising_r && mirror;
  assign comp = rising_r && mirror;
  assign wl_s = mirror ? ($signed({1'b0, cadsr_pkg::CURVE_UNIT}) - crv_x)
                       : ($signed({1'b0, cadsr_pkg::CURVE_UNIT}) + crv_x);
  assign wt_s = mirror ? crv_x : -crv_x;
  assign w_lin = wl_s[cadsr_pkg::WGT_W-1:0];
  assign w_tab = wt_s[cadsr_pkg::WGT_W-1:0];
  assign tv = inv ? (ONE - ram_rdata) : ram_rdata;

  assign ram_we = in_xfer && (in_ch.func == cadsr_pkg::FN_TWRITE)
                  && (32'(in_ch.table_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_ch.table_index);
  assign ram_wdata = (in_ch.table_value > ONE) ? ONE : in_ch.table_value;

  always_comb begin
    logic [XW:0] xa;
    xa = (state_r == S_CV2) ? ((XW + 1)'(x_r) + 1'b1) : (XW + 1)'(x_r);
    ram_raddr = (xa > (XW + 1)'(X_MAX)) ? AW'(X_MAX) : AW'(xa);
  end

  cadsr_ram #(
    .WIDTH(LW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_step_r <= ONE;
      decay_step_r <= ONE;
      release_step_r <= ONE;
      sustain_r <= ONE;
      attack_curve_r <= '0;
      fall_curve_r <= '0;
      cycle_len_r <= '0;
      mode_r <= 3'd4;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        cadsr_pkg::REG_ATTACK_STEP: attack_step_r <= LW'(cfg_ch.data);
        cadsr_pkg::REG_DECAY_STEP: decay_step_r <= LW'(cfg_ch.data);
        cadsr_pkg::REG_RELEASE_STEP: release_step_r <= LW'(cfg_ch.data);
        cadsr_pkg::REG_SUSTAIN: sustain_r <= LW'(cfg_ch.data);
        cadsr_pkg::REG_ATTACK_CURVE: attack_curve_r <= cfg_ch.data[15:0];
        cadsr_pkg::REG_FALL_CURVE: fall_curve_r <= cfg_ch.data[15:0];
        cadsr_pkg::REG_CYCLE_LEN: cycle_len_r <= cfg_ch.data;
        cadsr_pkg::REG_MODE: mode_r <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [POS_W-1:0] fwd, rev, sel;
    logic [LW:0] sum, mid_sum;
    logic [LW+1:0] lk;
    logic [BW:0] bsum;
    logic [LW-1:0] lkc, ix, lv, og, d, mult;
    logic [cadsr_pkg::PHASE_W-1:0] ph;
    logic [cadsr_pkg::CYC_W-1:0] el;
    logic above, go;

    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt = idx_r;
    level_nxt = level_r;
    origin_nxt = origin_r;
    elapsed_nxt = elapsed_r;
    due_nxt = due_r;
    cyc_nxt = cyc_r;
    rising_nxt = rising_r;
    search_nxt = search_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    mid_nxt = mid_r;
    steps_nxt = steps_r;
    cv_idx_nxt = cv_idx_r;
    x_nxt = x_r;
    frac_nxt = frac_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    prod_nxt = prod_r;
    term_nxt = term_r;
    cv_nxt = cv_r;
    bw1_nxt = bw1_r;
    bw2_nxt = bw2_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_phase_nxt = out_phase_r;

    fwd = '0;
    rev = '0;
    sel = '0;
    sum = '0;
    mid_sum = '0;
    lk = '0;
    bsum = '0;
    lkc = '0;
    d = '0;
    mult = '0;
    above = 1'b0;
    go = 1'b0;
    ix = idx_r;
    lv = level_r;
    og = origin_r;
    ph = phase_r;
    el = elapsed_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.func)
            cadsr_pkg::FN_TICK: state_nxt = S_PREP;
            cadsr_pkg::FN_ON: begin
              idx_nxt = on_idx;
              elapsed_nxt = '0;
              phase_nxt = on_phase;
            end
            cadsr_pkg::FN_OFF: begin
              if (phase_r != cadsr_pkg::PH_IDLE) begin
                if (mode_r[2]) begin
                  phase_nxt = cadsr_pkg::PH_REL;
                  idx_nxt = ONE;
                  origin_nxt = level_r;
                end else begin
                  phase_nxt = cadsr_pkg::PH_IDLE;
                  idx_nxt = '0;
                  level_nxt = '0;
                  origin_nxt = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        el = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
        elapsed_nxt = el;
        due_nxt = (el >= cycle_len_r);
        cyc_nxt = (phase_r >= cadsr_pkg::PH_CATT);
        state_nxt = S_OUT;
        case (phase_r)
          cadsr_pkg::PH_IDLE: level_nxt = '0;
          cadsr_pkg::PH_ATT, cadsr_pkg::PH_CATT: begin
            sum = (LW + 1)'(idx_r) + (LW + 1)'(attack_step_r);
            ix = (sum > (LW + 1)'(ONE)) ? ONE : sum[LW-1:0];
            idx_nxt = ix;
            cv_idx_nxt = ix;
            rising_nxt = 1'b1;
            state_nxt = S_CV0;
          end
          cadsr_pkg::PH_DEC, cadsr_pkg::PH_CDEC: begin
            ix = (decay_step_r > idx_r) ? '0 : idx_r - decay_step_r;
            idx_nxt = ix;
            cv_idx_nxt = ix;
            rising_nxt = 1'b0;
            state_nxt = S_CV0;
          end
          cadsr_pkg::PH_SUS: begin
            idx_nxt = ONE;
            level_nxt = sus;
            origin_nxt = sus;
          end
          cadsr_pkg::PH_REL, cadsr_pkg::PH_CREL: begin
            rising_nxt = 1'b0;
            if (idx_r == ONE) begin
              lo_nxt = '0;
              hi_nxt = ONE;
              mid_nxt = ONE >> 1;
              cv_idx_nxt = ONE >> 1;
              steps_nxt = '0;
              search_nxt = 1'b1;
              state_nxt = S_CV0;
            end else begin
              state_nxt = S_RELC;
            end
          end
          cadsr_pkg::PH_WAIT: begin
            level_nxt = '0;
            if (el >= cycle_len_r) begin
              idx_nxt = on_idx;
              elapsed_nxt = '0;
              phase_nxt = on_phase;
            end
          end
          default: begin
            level_nxt = '0;
            phase_nxt = cadsr_pkg::PH_IDLE;
          end
        endcase
      end
      S_RELC: begin
        ix = (release_step_r > idx_r) ? '0 : idx_r - release_step_r;
        if (cyc_r && ix > cadsr_pkg::HI_CLAMP) begin
          ix = cadsr_pkg::HI_CLAMP;
        end
        idx_nxt = ix;
        cv_idx_nxt = ix;
        search_nxt = 1'b0;
        state_nxt = S_CV0;
      end
      S_CV0: begin
        ix = (cv_idx_r > ONE) ? ONE : cv_idx_r;
        cv_idx_nxt = ix;
        fwd = POS_W'(ix) * POS_W'(TABLE_DEPTH);
        rev = POS_W'(ONE - ix) * POS_W'(TABLE_DEPTH);
        sel = mirror ? rev : fwd;
        frac_nxt = rising_r ? sel[FB-1:0] : fwd[FB-1:0];
        x_nxt = XW'(sel >> FB);
        state_nxt = S_CV1;
      end
      S_CV1: state_nxt = S_CV2;
      S_CV2: begin
        p1_nxt = PW'(tv) * PW'(ONE - LW'(frac_r));
        state_nxt = S_CV3;
      end
      S_CV3: begin
        p2_nxt = PW'(tv) * PW'(frac_r);
        state_nxt = S_CV4;
      end
      S_CV4: begin
        lk = (LW + 2)'(p1_r >> FB) + (LW + 2)'(p2_r >> FB);
        lkc = (lk > (LW + 2)'(ONE)) ? ONE : lk[LW-1:0];
        term_nxt = comp ? (ONE - lkc) : lkc;
        bw1_nxt = BW'(w_lin) * BW'(cv_idx_r);
        state_nxt = S_CV5;
      end
      S_CV5: begin
        bw2_nxt = BW'(w_tab) * BW'(term_r);
        state_nxt = S_CV6;
      end
      S_CV6: begin
        bsum = ((BW + 1)'(bw1_r) + (BW + 1)'(bw2_r)) >> 15;
        cv_nxt = (bsum > (BW + 1)'(ONE)) ? ONE : bsum[LW-1:0];
        if (search_r) begin
          state_nxt = S_SRCH;
        end else if (phase_r == cadsr_pkg::PH_ATT || phase_r == cadsr_pkg::PH_CATT) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SRCH: begin
        above = (cv_r > ONE);
        d = above ? (cv_r - ONE) : (ONE - cv_r);
        if (d <= cadsr_pkg::TOL || 32'(steps_r) >= SEARCH_STEPS) begin
          idx_nxt = mid_r;
          state_nxt = S_RELC;
        end else begin
          if (above) begin
            hi_nxt = mid_r;
            mid_sum = (LW + 1)'(lo_r) + (LW + 1)'(mid_r);
          end else begin
            lo_nxt = mid_r;
            mid_sum = (LW + 1)'(mid_r) + (LW + 1)'(hi_r);
          end
          mid_nxt = mid_sum[LW:1];
          cv_idx_nxt = mid_sum[LW:1];
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_CV0;
        end
      end
      S_SCALE: begin
        mult = (phase_r == cadsr_pkg::PH_DEC || phase_r == cadsr_pkg::PH_CDEC)
               ? (ONE - sus) : origin_r;
        prod_nxt = PW'(cv_r) * PW'(mult);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        case (phase_r)
          cadsr_pkg::PH_ATT, cadsr_pkg::PH_CATT: begin
            lv = cv_r;
            og = lv;
            if (cyc_r && due_r) begin
              lv = '0;
              og = '0;
              ix = on_idx;
              el = '0;
              ph = on_phase;
            end
            if (ix >= cadsr_pkg::HI_MARK) begin
              lv = ONE;
              og = ONE;
              go = 1'b1;
            end
          end
          cadsr_pkg::PH_DEC, cadsr_pkg::PH_CDEC: begin
            lv = sus + LW'(prod_r >> FB);
            og = lv;
            if (cyc_r && due_r) begin
              ix = on_idx;
              el = '0;
              ph = on_phase;
            end
            go = (lv <= sus);
          end
          default: begin
            lv = LW'(prod_r >> FB);
            if (cyc_r && due_r) begin
              ix = on_idx;
              el = '0;
              ph = on_phase;
            end
            go = (ix <= cadsr_pkg::LO_MARK);
          end
        endcase
        if (go) begin
          case (ph)
            cadsr_pkg::PH_ATT: begin
              ph = cadsr_pkg::PH_DEC;
              ix = ONE;
            end
            cadsr_pkg::PH_CATT: begin
              ph = cadsr_pkg::PH_CDEC;
              ix = ONE;
            end
            cadsr_pkg::PH_DEC: begin
              ph = cadsr_pkg::PH_SUS;
              ix = ONE;
            end
            cadsr_pkg::PH_CDEC: begin
              ph = cadsr_pkg::PH_CREL;
              ix = ONE;
            end
            cadsr_pkg::PH_REL: begin
              ph = cadsr_pkg::PH_IDLE;
              ix = '0;
              lv = '0;
              og = '0;
            end
            cadsr_pkg::PH_CREL: begin
              if (mode_r[1]) begin
                ph = cadsr_pkg::PH_WAIT;
              end else begin
                ix = on_idx;
                el = '0;
                ph = on_phase;
              end
            end
            default: ph = cadsr_pkg::PH_IDLE;
          endcase
        end
        phase_nxt = ph;
        idx_nxt = ix;
        level_nxt = lv;
        origin_nxt = og;
        elapsed_nxt = el;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = (level_r > ONE) ? ONE : level_r;
          out_phase_nxt = phase_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= cadsr_pkg::PH_IDLE;
      idx_r <= '0;
      level_r <= '0;
      origin_r <= '0;
      elapsed_r <= '0;
      search_r <= 1'b0;
      steps_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r <= idx_nxt;
      level_r <= level_nxt;
      origin_r <= origin_nxt;
      elapsed_r <= elapsed_nxt;
      search_r <= search_nxt;
      steps_r <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    cyc_r <= cyc_nxt;
    rising_r <= rising_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    cv_idx_r <= cv_idx_nxt;
    x_r <= x_nxt;
    frac_r <= frac_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    prod_r <= prod_nxt;
    term_r <= term_nxt;
    cv_r <= cv_nxt;
    bw1_r <= bw1_nxt;
    bw2_r <= bw2_nxt;
    out_level_r <= out_level_nxt;
    out_phase_r <= out_phase_nxt;
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(steps_r) <= SEARCH_STEPS)
    else $error("search step count overran");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= ONE)
    else $error("phase index above one");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= cadsr_pkg::PH_WAIT)
    else $error("phase code out of range");

endmodule

@@ tb/sv/envelope_checker.sv @@
`timescale 1ns / 1ps

module envelope_checker (
  input logic clk,
  input logic rst_n,
  cadsr_cfg_if cfg_ch,
  cadsr_in_if in_ch,
  cadsr_out_if out_ch,
  output int errors,
  output int pending
);

  typedef longint unsigned u64_t;

  localparam u64_t UNIT = 64'd1 << cadsr_pkg::FB;
  localparam u64_t UNIT_MASK = UNIT - 1;
  localparam int DEPTH = cadsr_pkg::TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [cadsr_pkg::LVL_W-1:0] level;
    logic [cadsr_pkg::PHASE_W-1:0] phase;
  } env_result_t;

  env_result_t expected_levels[$];

  u64_t atk_step, dec_step, rel_step, sus_level, cyc_len;
  logic [cadsr_pkg::CURVE_W-1:0] atk_curve, fall_curve;
  logic [cadsr_pkg::MODE_W-1:0] mode;

  logic [cadsr_pkg::PHASE_W-1:0] env_phase;
  u64_t env_index, env_level, env_origin, env_elapsed;
  u64_t shape_table[DEPTH];

  function automatic u64_t mul_frac(u64_t a, u64_t b);
    u64_t hi, lo;
    hi = a * (b >> 16);
    lo = a * (b & 64'hFFFF);
    return (hi + (lo >> 16)) >> (cadsr_pkg::FB - 16);
  endfunction

  function automatic u64_t table_entry(u64_t i, bit inv);
    u64_t v;
    if (i > DEPTH - 1) i = DEPTH - 1;
    v = shape_table[i];
    return inv ? UNIT - v : v;
  endfunction

  function automatic u64_t shape_level(u64_t idx, bit rising);
    int c;
    u64_t fwd, rev, x, frac, l1, l2, lk, term, wl, wt;
    bit mirror, inv, comp;
    c = rising ? int'($signed(atk_curve)) : int'($signed(fall_curve));
    inv = 0;
    comp = 0;
    if (idx > UNIT) idx = UNIT;
    fwd = idx * DEPTH;
    rev = (UNIT - idx) * DEPTH;
    if (rising) begin
      mirror = c > 0;
      frac = (mirror ? rev : fwd) & UNIT_MASK;
      comp = mirror;
    end else begin
      mirror = c >= 0;
      frac = fwd & UNIT_MASK;
      inv = mirror;
    end
    x = (mirror ? rev : fwd) >> cadsr_pkg::FB;
    l1 = table_entry(x, inv);
    l2 = table_entry(x + 1, inv);
    lk = mul_frac(l1, UNIT - frac) + mul_frac(l2, frac);
    if (lk > UNIT) lk = UNIT;
    term = comp ? UNIT - lk : lk;
    if (mirror) begin
      wl = u64_t'(32768 - c);
      wt = u64_t'(c);
    end else begin
      wl = u64_t'(32768 + c);
      wt = u64_t'(-c);
    end
    lk = (wl * idx + wt * term) >> 15;
    return lk > UNIT ? UNIT : lk;
  endfunction

  function automatic u64_t search_release(u64_t target);
    u64_t lo, hi, mid, v, d;
    int steps;
    bit above;
    lo = 0;
    hi = UNIT;
    mid = UNIT / 2;
    steps = 0;
    while (1) begin
      v = shape_level(mid, 0);
      above = v > target;
      d = above ? v - target : target - v;
      if (d <= u64_t'(cadsr_pkg::TOL) || steps >= cadsr_pkg::SEARCH_STEPS_DEF) break;
      if (above) hi = mid;
      else lo = mid;
      mid = (lo + hi) / 2;
      steps++;
    end
    return mid;
  endfunction

  function automatic u64_t sub_floor(u64_t a, u64_t b);
    return b > a ? 0 : a - b;
  endfunction

  task automatic clear_envelope();
    env_phase = cadsr_pkg::PH_IDLE;
    env_index = 0;
    env_level = 0;
    env_origin = 0;
  endtask

  task automatic start_note();
    env_index = 0;
    env_elapsed = 0;
    env_phase = (mode[1:0] != 0) ? cadsr_pkg::PH_CATT : cadsr_pkg::PH_ATT;
  endtask

  task automatic next_segment();
    case (env_phase)
      cadsr_pkg::PH_ATT: begin env_phase = cadsr_pkg::PH_DEC; env_index = UNIT; end
      cadsr_pkg::PH_CATT: begin env_phase = cadsr_pkg::PH_CDEC; env_index = UNIT; end
      cadsr_pkg::PH_DEC: begin env_phase = cadsr_pkg::PH_SUS; env_index = UNIT; end
      cadsr_pkg::PH_CDEC: begin env_phase = cadsr_pkg::PH_CREL; env_index = UNIT; end
      cadsr_pkg::PH_REL: clear_envelope();
      cadsr_pkg::PH_CREL: begin
        if (mode[1]) env_phase = cadsr_pkg::PH_WAIT;
        else start_note();
      end
      default: env_phase = cadsr_pkg::PH_IDLE;
    endcase
  endtask

  task automatic advance_tick();
    u64_t s;
    bit cyc, due;
    s = sus_level > UNIT ? UNIT : sus_level;
    cyc = env_phase >= cadsr_pkg::PH_CATT;
    if (env_elapsed < 64'hFFFF_FFFF) env_elapsed++;
    due = env_elapsed >= cyc_len;
    case (env_phase)
      cadsr_pkg::PH_IDLE: env_level = 0;
      cadsr_pkg::PH_ATT, cadsr_pkg::PH_CATT: begin
        env_index += atk_step;
        if (env_index > UNIT) env_index = UNIT;
        env_level = shape_level(env_index, 1);
        env_origin = env_level;
        if (cyc && due) begin
          env_level = 0;
          env_origin = 0;
          start_note();
        end
        if (env_index >= u64_t'(cadsr_pkg::HI_MARK)) begin
          env_level = UNIT;
          env_origin = UNIT;
          next_segment();
        end
      end
      cadsr_pkg::PH_DEC, cadsr_pkg::PH_CDEC: begin
        env_index = sub_floor(env_index, dec_step);
        env_level = s + mul_frac(shape_level(env_index, 0), UNIT - s);
        env_origin = env_level;
        if (cyc && due) start_note();
        if (env_level <= s) next_segment();
      end
      cadsr_pkg::PH_SUS: begin
        env_index = UNIT;
        env_level = s;
        env_origin = s;
      end
      cadsr_pkg::PH_REL, cadsr_pkg::PH_CREL: begin
        if (env_index == UNIT) env_index = search_release(env_index);
        env_index = sub_floor(env_index, rel_step);
        if (cyc && env_index > u64_t'(cadsr_pkg::HI_CLAMP)) begin
          env_index = u64_t'(cadsr_pkg::HI_CLAMP);
        end
        env_level = mul_frac(shape_level(env_index, 0), env_origin);
        if (cyc && due) start_note();
        if (env_index <= u64_t'(cadsr_pkg::LO_MARK)) next_segment();
      end
      cadsr_pkg::PH_WAIT: begin
        env_level = 0;
        if (due) start_note();
      end
      default: begin
        env_level = 0;
        env_phase = cadsr_pkg::PH_IDLE;
      end
    endcase
  endtask

  task automatic apply_event(logic [cadsr_pkg::FUNC_W-1:0] fn,
                             logic [cadsr_pkg::TIDX_W-1:0] idx,
                             logic [cadsr_pkg::LVL_W-1:0] val);
    env_result_t r;
    case (fn)
      cadsr_pkg::FN_ON: start_note();
      cadsr_pkg::FN_OFF: begin
        if (env_phase != cadsr_pkg::PH_IDLE) begin
          if (mode[2]) begin
            env_phase = cadsr_pkg::PH_REL;
            env_index = UNIT;
            env_origin = env_level;
          end else begin
            clear_envelope();
          end
        end
      end
      cadsr_pkg::FN_TWRITE: shape_table[idx] = (u64_t'(val) > UNIT) ? UNIT : u64_t'(val);
      default: begin
        advance_tick();
        r.level = cadsr_pkg::LVL_W'(env_level > UNIT ? UNIT : env_level);
        r.phase = env_phase;
        expected_levels.push_back(r);
      end
    endcase
  endtask

  task automatic write_register(logic [cadsr_pkg::CFG_IDX_W-1:0] idx,
                                logic [cadsr_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      cadsr_pkg::REG_ATTACK_STEP: atk_step = u64_t'(d[cadsr_pkg::LVL_W-1:0]);
      cadsr_pkg::REG_DECAY_STEP: dec_step = u64_t'(d[cadsr_pkg::LVL_W-1:0]);
      cadsr_pkg::REG_RELEASE_STEP: rel_step = u64_t'(d[cadsr_pkg::LVL_W-1:0]);
      cadsr_pkg::REG_SUSTAIN: sus_level = u64_t'(d[cadsr_pkg::LVL_W-1:0]);
      cadsr_pkg::REG_ATTACK_CURVE: atk_curve = d[cadsr_pkg::CURVE_W-1:0];
      cadsr_pkg::REG_FALL_CURVE: fall_curve = d[cadsr_pkg::CURVE_W-1:0];
      cadsr_pkg::REG_CYCLE_LEN: cyc_len = u64_t'(d);
      cadsr_pkg::REG_MODE: mode = d[cadsr_pkg::MODE_W-1:0];
      default: ;
    endcase
  endtask

  assign pending = expected_levels.size();

  always @(posedge clk) begin
    env_result_t e;
    if (!rst_n) begin
      atk_step = UNIT;
      dec_step = UNIT;
      rel_step = UNIT;
      sus_level = UNIT;
      atk_curve = '0;
      fall_curve = '0;
      cyc_len = 0;
      mode = 3'd4;
      clear_envelope();
      env_elapsed = 0;
      expected_levels.delete();
      errors = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected result transfer: level %0d phase %0d",
                 out_ch.level, out_ch.phase);
          errors++;
        end else begin
          e = expected_levels.pop_front();
          if (out_ch.level !== e.level) begin
            $error("level: expected %0d actual %0d", e.level, out_ch.level);
            errors++;
          end
          if (out_ch.phase !== e.phase) begin
            $error("phase: expected %0d actual %0d", e.phase, out_ch.phase);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        apply_event(in_ch.func, in_ch.table_index, in_ch.table_value);
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 2000000;
  localparam int SETTLE = 400;
  localparam logic [cadsr_pkg::LVL_W-1:0] FULL = cadsr_pkg::ONE;
  localparam logic [31:0] FULL32 = 32'(cadsr_pkg::ONE);

  logic clk = 0;
  logic rst_n = 0;
  bit calm = 0;
  int errors, pending;
  int cycles = 0;

  cadsr_cfg_if cfg_ch ();
  cadsr_in_if in_ch ();
  cadsr_out_if out_ch ();

  curved_adsr_envelope u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_ch(cfg_ch),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  envelope_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_ch(cfg_ch),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready = calm || ($urandom_range(0, 99) >= 8);
    end
  end

  task automatic reg_write(logic [cadsr_pkg::CFG_IDX_W-1:0] idx,
                           logic [cadsr_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid = 1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic send(logic [cadsr_pkg::FUNC_W-1:0] fn,
                      logic [cadsr_pkg::TIDX_W-1:0] idx = '0,
                      logic [cadsr_pkg::LVL_W-1:0] val = '0);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.func = fn;
    in_ch.table_index = idx;
    in_ch.table_value = val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] as, logic [31:0] ds, logic [31:0] rs,
                           logic [31:0] sl, logic [31:0] ac, logic [31:0] fc,
                           logic [31:0] cl, logic [31:0] mf);
    settle();
    reg_write(cadsr_pkg::REG_ATTACK_STEP, as);
    reg_write(cadsr_pkg::REG_DECAY_STEP, ds);
    reg_write(cadsr_pkg::REG_RELEASE_STEP, rs);
    reg_write(cadsr_pkg::REG_SUSTAIN, sl);
    reg_write(cadsr_pkg::REG_ATTACK_CURVE, ac);
    reg_write(cadsr_pkg::REG_FALL_CURVE, fc);
    reg_write(cadsr_pkg::REG_CYCLE_LEN, cl);
    reg_write(cadsr_pkg::REG_MODE, mf);
  endtask

  function automatic logic [31:0] rand_step();
    return (FULL32 >> $urandom_range(2, 9)) + $urandom_range(0, 255);
  endfunction

  task automatic play(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) send(cadsr_pkg::FN_TWRITE,
                      cadsr_pkg::TIDX_W'($urandom_range(0, 1023)),
                      cadsr_pkg::LVL_W'($urandom_range(0, 32'h1FF_FFFF)));
      else if (r < 9) send(cadsr_pkg::FN_ON);
      else if (r < 15) send(cadsr_pkg::FN_OFF);
      else send(cadsr_pkg::FN_TICK);
    end
  endtask

  initial begin
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 0;
    in_ch.func = cadsr_pkg::FN_TICK;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int i = 0; i < 1024; i++) begin
      if (i == 1023) begin
        send(cadsr_pkg::FN_TWRITE, cadsr_pkg::TIDX_W'(i), FULL);
      end else if (i == 700) begin
        send(cadsr_pkg::FN_TWRITE, cadsr_pkg::TIDX_W'(i), 25'h1FF_FFFF);
      end else if (i % 97 == 5) begin
        send(cadsr_pkg::FN_TWRITE, cadsr_pkg::TIDX_W'(i),
             cadsr_pkg::LVL_W'($urandom_range(0, FULL32)));
      end else begin
        send(cadsr_pkg::FN_TWRITE, cadsr_pkg::TIDX_W'(i), cadsr_pkg::LVL_W'(i * i * 16));
      end
    end
    send(cadsr_pkg::FN_TWRITE, cadsr_pkg::TIDX_W'(700), cadsr_pkg::LVL_W'(700 * 700 * 16));

    send(cadsr_pkg::FN_TICK);
    send(cadsr_pkg::FN_OFF);
    send(cadsr_pkg::FN_TICK);
    send(cadsr_pkg::FN_ON);
    repeat (4) send(cadsr_pkg::FN_TICK);
    send(cadsr_pkg::FN_OFF);
    repeat (3) send(cadsr_pkg::FN_TICK);
    send(cadsr_pkg::FN_ON);
    send(cadsr_pkg::FN_TICK);
    send(cadsr_pkg::FN_OFF);
    repeat (2) send(cadsr_pkg::FN_TICK);

    configure(FULL32 >> 4, FULL32 >> 5, FULL32 >> 5, FULL32 >> 1, 32767, 32'hFFFF_8000,
              0, 4);
    play(100);
    configure(FULL32 >> 3, FULL32 >> 6, FULL32 >> 4, 0, 32'hFFFF_8000, 32767, 40, 5);
    play(100);
    configure(FULL32 >> 5, FULL32 >> 4, FULL32 >> 3, 32'h1FF_FFFF, 16000, 32'hFFFF_D120,
              60, 6);
    play(100);
    configure(1, 0, 0, FULL32, 0, 0, 32'hFFFF_FFFF, 3);
    play(40);
    calm = 1;
    configure(rand_step(), rand_step(), rand_step(), $urandom_range(0, FULL32),
              $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
    play(120);
    calm = 0;
    configure(rand_step(), rand_step(), rand_step(), $urandom_range(0, FULL32),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 200), $urandom_range(0, 7));
    play(120);
    configure(rand_step(), rand_step(), rand_step(), $urandom_range(0, FULL32),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(5, 80), 7);
    play(120);
    configure(FULL32, FULL32, FULL32, 0, $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 30), $urandom_range(0, 7));
    play(100);
    configure(rand_step(), rand_step(), rand_step(), $urandom_range(0, FULL32),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 120), $urandom_range(0, 7));
    play(110);

    settle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
